FILE: design/cmnp_pkg.sv
// ----------------------------------------------------------------------------
// cmnp_pkg
// Shared types and constants for the console mouse nibble port.
// ----------------------------------------------------------------------------
`default_nettype none

package cmnp_pkg;

  // Width of the raw cursor movement fields.
  localparam int RAW_DELTA_BITS = 13;
  localparam int DIV_CNT_W      = $clog2(RAW_DELTA_BITS);

  localparam int TICK_W   = 24;
  localparam int TIMER_W  = 22;
  localparam int DELTA_W  = 8;
  localparam int MAG_W    = 3;
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;

  localparam int ACCEL_THRESHOLD = 64;
  localparam int DELTA_LIMIT     = 127;

  localparam logic [MAG_W-1:0]    MAG_RESET      = 3'd1;
  localparam logic [TICK_W-1:0]   INTERVAL_RESET = 24'd7457;
  localparam logic [TIMER_W-1:0]  HOLD_RESET     = 22'd2386363;

  typedef enum logic [2:0] {
    OP_TICK         = 3'd0,
    OP_RESET        = 3'd1,
    OP_FRAME_UPDATE = 3'd2,
    OP_READ_DELTA   = 3'd3,
    OP_READ_BUTTONS = 3'd4,
    OP_SET_BUTTON   = 3'd5,
    OP_WHEEL        = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    REG_MAGNIFICATION = 3'd0,
    REG_MOUSE_CONN    = 3'd1,
    REG_SWAP_SEL_RUN  = 3'd2,
    REG_SWAP_ONE_TWO  = 3'd3,
    REG_RESET_INTERVAL = 3'd4,
    REG_WHEEL_HOLD    = 3'd5
  } reg_index_t;

  // Nibble read sequence positions.
  typedef enum logic [2:0] {
    STEP_X_HIGH = 3'd0,
    STEP_X_LOW  = 3'd1,
    STEP_Y_HIGH = 3'd2,
    STEP_Y_LOW  = 3'd3,
    STEP_DONE   = 3'd4
  } read_step_t;

endpackage

`default_nettype wire

FILE: design/console_mouse_nibble_port.sv
// ----------------------------------------------------------------------------
// console_mouse_nibble_port
// Emulated console mouse read by the CPU one nibble at a time.
//
// A delta or button read fills the output register, and its result transfer
// is offered from the cycle after it is accepted. Ticks, reset ops, button
// sets, wheel ops and frame updates with no mouse connected finish in idle.
// A connected frame update holds the input off while the shared bit-serial
// divider runs once per axis, each run followed by a scale state, then commit.
// Any new item also waits while an earlier result transfer is stalled.
// Reset (rst, synchronous) restores register defaults and the mouse state.
// ----------------------------------------------------------------------------
`default_nettype none

module console_mouse_nibble_port (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // Input channel.
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic [2:0]                             op,
  input  wire logic signed [cmnp_pkg::RAW_DELTA_BITS-1:0] raw_dx,
  input  wire logic signed [cmnp_pkg::RAW_DELTA_BITS-1:0] raw_dy,
  input  wire logic                                   wide_video,
  input  wire logic                                   overclock_tick,
  input  wire logic [1:0]                             button_index,
  input  wire logic                                   button_pressed,
  input  wire logic [3:0]                             pad_buttons,
  // Output channel.
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic [3:0]                                  read_data,
  output logic                                        wheel_busy,
  // Configuration port.
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [cmnp_pkg::PADDR_W-1:0]           paddr,
  input  wire logic [cmnp_pkg::PDATA_W-1:0]           pwdata,
  output logic [cmnp_pkg::PDATA_W-1:0]                prdata,
  output logic                                        pready
);

  localparam int N = cmnp_pkg::RAW_DELTA_BITS;

  // The frame update sequencer. Every other op finishes while in idle.
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DIV    = 4'b0010,
    ST_SCALE  = 4'b0100,
    ST_COMMIT = 4'b1000
  } state_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [cmnp_pkg::MAG_W-1:0]   magnification;
  logic                         mouse_connected;
  logic                         swap_select_run;
  logic                         swap_one_two;
  logic [cmnp_pkg::TICK_W-1:0]  reset_interval;
  logic [cmnp_pkg::TIMER_W-1:0] wheel_hold_ticks;

  logic                         cfg_write;
  cmnp_pkg::reg_index_t         cfg_sel;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign cfg_sel   = cmnp_pkg::reg_index_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      magnification    <= cmnp_pkg::MAG_RESET;
      mouse_connected  <= 1'b0;
      swap_select_run  <= 1'b0;
      swap_one_two     <= 1'b0;
      reset_interval   <= cmnp_pkg::INTERVAL_RESET;
      wheel_hold_ticks <= cmnp_pkg::HOLD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        cmnp_pkg::REG_MAGNIFICATION:  magnification    <= pwdata[cmnp_pkg::MAG_W-1:0];
        cmnp_pkg::REG_MOUSE_CONN:     mouse_connected  <= pwdata[0];
        cmnp_pkg::REG_SWAP_SEL_RUN:   swap_select_run  <= pwdata[0];
        cmnp_pkg::REG_SWAP_ONE_TWO:   swap_one_two     <= pwdata[0];
        cmnp_pkg::REG_RESET_INTERVAL: reset_interval   <= pwdata[cmnp_pkg::TICK_W-1:0];
        cmnp_pkg::REG_WHEEL_HOLD:     wheel_hold_ticks <= pwdata[cmnp_pkg::TIMER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register reads are zero-extended; addresses past the list read as zero.
  always_comb begin
    unique case (cfg_sel)
      cmnp_pkg::REG_MAGNIFICATION:  prdata = cmnp_pkg::PDATA_W'(magnification);
      cmnp_pkg::REG_MOUSE_CONN:     prdata = cmnp_pkg::PDATA_W'(mouse_connected);
      cmnp_pkg::REG_SWAP_SEL_RUN:   prdata = cmnp_pkg::PDATA_W'(swap_select_run);
      cmnp_pkg::REG_SWAP_ONE_TWO:   prdata = cmnp_pkg::PDATA_W'(swap_one_two);
      cmnp_pkg::REG_RESET_INTERVAL: prdata = cmnp_pkg::PDATA_W'(reset_interval);
      cmnp_pkg::REG_WHEEL_HOLD:     prdata = cmnp_pkg::PDATA_W'(wheel_hold_ticks);
      default:                      prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  // A new item is taken only in idle, and only when the output register is
  // free or is being emptied by a transfer in the same cycle.
  state_t state;
  logic   in_take;
  logic   out_load;
  cmnp_pkg::op_t op_code;

  assign in_stall = (state != ST_IDLE) | (out_valid & out_stall);
  assign in_take  = in_valid & ~in_stall;
  assign op_code  = cmnp_pkg::op_t'(op);
  // Only the two read ops fill the output register.
  assign out_load = in_take && (op_code == cmnp_pkg::OP_READ_DELTA ||
                                op_code == cmnp_pkg::OP_READ_BUTTONS);

  // --------------------------------------------------------------------------
  // Mouse state
  // --------------------------------------------------------------------------
  cmnp_pkg::read_step_t          read_step;
  logic [cmnp_pkg::DELTA_W-1:0]  delta_x;
  logic [cmnp_pkg::DELTA_W-1:0]  delta_y;
  logic                          take_x_next;
  logic [3:0]                    button_bits;
  logic [cmnp_pkg::TICK_W-1:0]   tick_count;
  logic [cmnp_pkg::TIMER_W-1:0]  wheel_timer;

  // --------------------------------------------------------------------------
  // Shared divider datapath
  // --------------------------------------------------------------------------
  // One restoring divider handles both axes in turn. The magnitude of the raw
  // movement leaves the top of the register into rem while quotient bits fill
  // the bottom of it; after N steps quo holds the quotient and rem the
  // remainder. Divisor zero is treated as one.
  logic [N-1:0]                  quo;
  logic [cmnp_pkg::MAG_W-1:0]    rem;
  logic [cmnp_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [N-1:0]                  y_mag;
  logic                          neg_x;
  logic                          neg_y;
  logic                          wide_q;
  logic                          axis_y;
  logic [cmnp_pkg::DELTA_W-1:0]  scaled_x;

  logic [cmnp_pkg::MAG_W-1:0]    divisor;
  logic [cmnp_pkg::MAG_W:0]      rem_shift;
  logic [cmnp_pkg::MAG_W:0]      rem_sub;
  logic                          q_bit;
  logic [N-1:0]                  dx_u;
  logic [N-1:0]                  dy_u;
  logic [N-1:0]                  dx_mag;
  logic [N-1:0]                  dy_mag;

  assign divisor   = (magnification == '0) ? cmnp_pkg::MAG_W'(1) : magnification;
  assign rem_shift = {rem, quo[N-1]};
  assign rem_sub   = rem_shift - {1'b0, divisor};
  assign q_bit     = (rem_shift >= {1'b0, divisor});

  assign dx_u   = raw_dx;
  assign dy_u   = raw_dy;
  assign dx_mag = dx_u[N-1] ? (~dx_u + N'(1)) : dx_u;
  assign dy_mag = dy_u[N-1] ? (~dy_u + N'(1)) : dy_u;

  // Rounding away from zero adds one to the magnitude when anything is left.
  // Magnitudes of 64 or more grow by half on the positive side and shrink by
  // half on the negative side, then both clamp at 127.
  logic [N-1:0] round_mag;
  logic [N:0]   round_ext;
  logic [N:0]   grown;
  logic [N:0]   accel_mag;
  logic [6:0]   clamp_mag;
  logic         axis_neg;
  logic [cmnp_pkg::DELTA_W-1:0] scaled;

  always_comb begin
    axis_neg  = axis_y ? neg_y : neg_x;
    round_mag = quo + N'(rem != '0);
    round_ext = {1'b0, round_mag};
    grown     = axis_neg ? (round_ext - (round_ext >> 1)) : (round_ext + (round_ext >> 1));
    accel_mag = (round_mag >= N'(cmnp_pkg::ACCEL_THRESHOLD)) ? grown : round_ext;
    clamp_mag = (accel_mag > (N + 1)'(cmnp_pkg::DELTA_LIMIT)) ?
                7'(cmnp_pkg::DELTA_LIMIT) : accel_mag[6:0];
    scaled    = axis_neg ? (cmnp_pkg::DELTA_W'(0) - {1'b0, clamp_mag}) : {1'b0, clamp_mag};
  end

  // In wide video a single-step diagonal turns into alternating axis steps.
  logic x_unit;
  logic y_unit;
  logic diag_split;

  assign x_unit     = (scaled_x == 8'h01) || (scaled_x == 8'hFF);
  assign y_unit     = (delta_y == 8'h01) || (delta_y == 8'hFF);
  assign diag_split = wide_q & x_unit & y_unit;

  // --------------------------------------------------------------------------
  // Sequencer and divider registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_take && op_code == cmnp_pkg::OP_FRAME_UPDATE && mouse_connected) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_cnt == cmnp_pkg::DIV_CNT_W'(N - 1)) begin
            state <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          state <= axis_y ? ST_COMMIT : ST_DIV;
        end
        ST_COMMIT: begin
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        quo     <= dx_mag;
        y_mag   <= dy_mag;
        neg_x   <= dx_u[N-1];
        neg_y   <= dy_u[N-1];
        wide_q  <= wide_video;
        rem     <= '0;
        div_cnt <= '0;
        axis_y  <= 1'b0;
      end
      ST_DIV: begin
        quo     <= {quo[N-2:0], q_bit};
        rem     <= q_bit ? rem_sub[cmnp_pkg::MAG_W-1:0] : rem_shift[cmnp_pkg::MAG_W-1:0];
        div_cnt <= div_cnt + cmnp_pkg::DIV_CNT_W'(1);
      end
      ST_SCALE: begin
        if (!axis_y) begin
          scaled_x <= scaled;
          quo      <= y_mag;
          rem      <= '0;
          div_cnt  <= '0;
          axis_y   <= 1'b1;
        end
      end
      ST_COMMIT: begin
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Button read merge
  // --------------------------------------------------------------------------
  logic [3:0] btn_mouse;
  logic [3:0] btn_merged;
  logic [3:0] btn_swap_a;
  logic [3:0] btn_swap_b;

  always_comb begin
    // Mouse select and run held together count as neither.
    btn_mouse  = ((button_bits & 4'hC) == 4'hC) ? (button_bits & 4'h3) : button_bits;
    btn_merged = btn_mouse | pad_buttons;
    btn_swap_a = swap_select_run ?
                 {btn_merged[2], btn_merged[3], btn_merged[1:0]} : btn_merged;
    btn_swap_b = swap_one_two ?
                 {btn_swap_a[3:2], btn_swap_a[0], btn_swap_a[1]} : btn_swap_a;
  end

  // --------------------------------------------------------------------------
  // Op execution and output register
  // --------------------------------------------------------------------------
  logic [3:0] delta_nibble;

  always_comb begin
    unique case (read_step)
      cmnp_pkg::STEP_X_HIGH: delta_nibble = delta_x[7:4];
      cmnp_pkg::STEP_X_LOW:  delta_nibble = delta_x[3:0];
      cmnp_pkg::STEP_Y_HIGH: delta_nibble = delta_y[7:4];
      cmnp_pkg::STEP_Y_LOW:  delta_nibble = delta_y[3:0];
      default:               delta_nibble = 4'h0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_step   <= cmnp_pkg::STEP_X_HIGH;
      delta_x     <= '0;
      delta_y     <= '0;
      take_x_next <= 1'b1;
      button_bits <= '0;
      tick_count  <= '0;
      wheel_timer <= '0;
      out_valid   <= 1'b0;
    end else begin
      // The output register empties on a transfer; a new read refills it.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (state == ST_SCALE && axis_y) begin
        delta_y <= scaled;
        delta_x <= scaled_x;
      end

      if (state == ST_COMMIT) begin
        if (diag_split) begin
          if (take_x_next) begin
            delta_y     <= '0;
            take_x_next <= 1'b0;
          end else begin
            delta_x     <= '0;
            take_x_next <= 1'b1;
          end
        end
      end

      if (in_take) begin
        unique case (op_code)
          cmnp_pkg::OP_TICK: begin
            if (tick_count != '1) begin
              tick_count <= tick_count + cmnp_pkg::TICK_W'(1);
            end
            if (wheel_timer != '0 && !overclock_tick) begin
              wheel_timer <= wheel_timer - cmnp_pkg::TIMER_W'(1);
              // Hold ends: select and run are released.
              if (wheel_timer == cmnp_pkg::TIMER_W'(1)) begin
                button_bits <= button_bits & 4'h3;
              end
            end
          end
          cmnp_pkg::OP_RESET: begin
            if (tick_count > reset_interval) begin
              read_step  <= cmnp_pkg::STEP_X_HIGH;
              tick_count <= '0;
            end
          end
          cmnp_pkg::OP_FRAME_UPDATE: begin
            // Handled by the divider sequence.
          end
          cmnp_pkg::OP_READ_DELTA: begin
            read_data  <= delta_nibble;
            wheel_busy <= (wheel_timer != '0);
            unique case (read_step)
              cmnp_pkg::STEP_X_HIGH: read_step <= cmnp_pkg::STEP_X_LOW;
              cmnp_pkg::STEP_X_LOW:  read_step <= cmnp_pkg::STEP_Y_HIGH;
              cmnp_pkg::STEP_Y_HIGH: read_step <= cmnp_pkg::STEP_Y_LOW;
              cmnp_pkg::STEP_Y_LOW:  read_step <= cmnp_pkg::STEP_DONE;
              default: begin
                // Past the fourth nibble every read clears the deltas.
                delta_x   <= '0;
                delta_y   <= '0;
                read_step <= cmnp_pkg::STEP_DONE;
              end
            endcase
          end
          cmnp_pkg::OP_READ_BUTTONS: begin
            read_data  <= btn_swap_b ^ 4'hF;
            wheel_busy <= (wheel_timer != '0);
          end
          cmnp_pkg::OP_SET_BUTTON: begin
            button_bits[button_index] <= button_pressed;
          end
          cmnp_pkg::OP_WHEEL: begin
            wheel_timer <= wheel_hold_ticks;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/cmnp_checker.sv
// ----------------------------------------------------------------------------
// cmnp_checker
// Port-level checks for the console mouse nibble port.
// ----------------------------------------------------------------------------
`default_nettype none

module cmnp_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [2:0] op,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [3:0] read_data,
  input wire logic       wheel_busy
);

  logic in_xfer;
  logic is_read;

  assign in_xfer = in_valid & ~in_stall;
  assign is_read = (op == cmnp_pkg::OP_READ_DELTA) || (op == cmnp_pkg::OP_READ_BUTTONS);

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(wheel_busy))
    else $error("result changed while stalled");

  // Every read transfer yields a result in the next cycle.
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    in_xfer && is_read |=> out_valid)
    else $error("read gave no result");

  // Ops other than reads never produce a result.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    in_xfer && !is_read && !out_valid |=> !out_valid)
    else $error("result without a read");

  // No input is taken while a result is stalled.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken over a stalled result");

endmodule

bind console_mouse_nibble_port cmnp_checker u_cmnp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .op         (op),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .read_data  (read_data),
  .wheel_busy (wheel_busy)
);

`default_nettype wire
